// ===== rtl/apc_pkg.sv =====
// Package for the altitude PID thrust controller.
// Types, widths, register indexes, sequencer states and the saturate helper.
// No dependencies.
package apc_pkg;

    // field and datapath widths
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 31;
    localparam int COS_W     = 18;
    localparam int OP_W      = 33;
    localparam int PROD_W    = 2 * OP_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int S_TDATA_W = 216;
    localparam int M_TDATA_W = 32;

    // divider: quotient magnitude bits and remainder width
    localparam int DIV_STEPS = 33;
    localparam int CNT_W     = 6;
    localparam int REM_W     = COS_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ASCENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DESCENT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MASS        = 3'd5;

    // register reset values
    localparam logic [GAIN_W-1:0] RATE_RESET = 31'd6553600;
    localparam logic [GAIN_W-1:0] MASS_RESET = 31'd65536;

    // saturation bounds at product width
    localparam logic signed [PROD_W-1:0] Q_MAX_W = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] Q_MIN_W = -PROD_W'(64'sd2147483648);
    localparam logic signed [DATA_W-1:0] Q_MAX   = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN   = 32'sh8000_0000;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_ERR,
        ST_MPE,
        ST_MKP,
        ST_MKV,
        ST_MKI,
        ST_MACC,
        ST_ASAT,
        ST_DINIT,
        ST_DIV,
        ST_QSAT,
        ST_MTH,
        ST_THR,
        ST_RES
    } apc_state_t;

    // operand pair for the shared multiplier
    typedef struct packed {
        logic signed [OP_W-1:0] a;
        logic signed [OP_W-1:0] b;
    } apc_mul_op_t;

    // saturated value and overflow mark
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } apc_sat_t;

    function automatic apc_sat_t apc_sat(input logic signed [PROD_W-1:0] v);
        apc_sat_t r;
        if (v > Q_MAX_W) begin
            r.val = Q_MAX;
            r.ovf = 1'b1;
        end else if (v < Q_MIN_W) begin
            r.val = Q_MIN;
            r.ovf = 1'b1;
        end else begin
            r.val = v[DATA_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/apc_mul.sv =====
// Shared signed multiplier of the altitude controller, product registered.
// Depends on apc_pkg.
module apc_mul (
    input  logic                                   aclk,
    input  apc_pkg::apc_mul_op_t                   op,
    output logic signed [apc_pkg::PROD_W-1:0]      prod
);

    logic signed [apc_pkg::PROD_W-1:0] prod_reg;

    // full-width product, registered
    always_ff @(posedge aclk) begin
        prod_reg <= op.a * op.b;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/altitude_pid_thrust_control.sv =====
// Altitude PID thrust controller: one thrust word per input word, Q format with
// FRAC_BITS fraction bits. With R33 nonzero a word goes through nine sequencer
// steps around the one shared 33x33 multiplier, the one-bit-per-cycle divider,
// then four steps for quotient saturation, mass product, thrust saturation and
// output load; the sequencer then goes back to idle to take the next word. With
// R33 zero the divider, quotient saturation, mass product and thrust saturation
// are skipped. A quotient known to overflow skips the divider. The input side is
// not ready while a word is in work. A finished result waits in the output
// register while the next word is taken. If that register is still full, the
// output load step stalls until it drains.
// Depends on apc_pkg and apc_mul.
module altitude_pid_thrust_control #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] target_height, [63:32] target_climb, [95:64] measured_height,
    // [127:96] measured_climb, [159:128] feedforward_accel,
    // [190:160] time_step, [208:191] tilt_cosine, [215:209] zero
    input  logic [apc_pkg::S_TDATA_W-1:0]       s_tdata,
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] thrust
    output logic [apc_pkg::M_TDATA_W-1:0]       m_tdata,
    // [0] saturated
    output logic [0:0]                          m_tuser,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [apc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [apc_pkg::CFG_DAT_W-1:0]       cfg_data
);

    localparam int DATA_W = apc_pkg::DATA_W;
    localparam int GAIN_W = apc_pkg::GAIN_W;
    localparam int COS_W  = apc_pkg::COS_W;
    localparam int OP_W   = apc_pkg::OP_W;
    localparam int PROD_W = apc_pkg::PROD_W;
    localparam int REM_W  = apc_pkg::REM_W;
    localparam int CNT_W  = apc_pkg::CNT_W;
    localparam int QB     = apc_pkg::DIV_STEPS;
    // scaled dividend |num| << FRAC_BITS and its part above the quotient bits
    localparam int DVD_W  = DATA_W + FRAC_BITS;
    localparam int HI_W   = DVD_W - QB;
    localparam longint GRAV_L = (981 * (longint'(1) << FRAC_BITS) + 50) / 100;
    localparam logic signed [DATA_W:0] GRAVITY = (DATA_W + 1)'(GRAV_L);

    // ------------------------------------------------------------------
    // registers
    apc_pkg::apc_state_t state_reg, state_next;

    logic [GAIN_W-1:0] kp_reg, kv_reg, ki_reg, asc_reg, desc_reg, mass_reg;

    logic signed [DATA_W-1:0] th_reg, tc_reg, mh_reg, mc_reg, ff_reg;
    logic        [GAIN_W-1:0] dt_reg;
    logic signed [COS_W-1:0]  r33_reg;

    logic signed [DATA_W-1:0] tcc_reg, pe_reg, ve_reg, sum_reg, c_reg, res_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [DATA_W:0]   num_reg;
    logic        [REM_W-1:0]  d_reg, rem_reg;
    logic        [QB-1:0]     dq_reg;
    logic        [CNT_W-1:0]  cnt_reg;
    logic                     ovf_reg, neg_reg, flag_reg;

    logic                     m_tvalid_reg;
    logic [DATA_W-1:0]        m_tdata_reg;
    logic                     m_tuser_reg;

    // ------------------------------------------------------------------
    // shared multiplier
    apc_pkg::apc_mul_op_t     mul_op;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_sh;

    apc_mul u_mul (
        .aclk (aclk),
        .op   (mul_op),
        .prod (prod)
    );

    // floor of product / 2^FRAC_BITS
    assign prod_sh = prod >>> FRAC_BITS;

    // ------------------------------------------------------------------
    // handshakes
    logic s_acc, slot_free;
    assign s_acc     = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // combinational datapath pieces
    logic signed [DATA_W:0]   lo_w, hi_w, tc_w, tcc_w;
    apc_pkg::apc_sat_t        pe_s, ve_s, sum_s, acc_s, thr_s;
    logic signed [DATA_W:0]   num_neg;
    logic        [DATA_W-1:0] abs_num;
    logic signed [COS_W:0]    r33_neg;
    logic        [REM_W-1:0]  dmag;
    logic        [DVD_W-1:0]  dvd;
    logic        [HI_W-1:0]   dvd_hi;
    logic        [HI_W+REM_W-1:0] hi_ext, d_ext;
    logic                     q_ovf;
    logic        [REM_W:0]    trial;
    logic                     trial_ge;
    logic        [REM_W:0]    trial_sub;
    logic        [QB:0]       mag_neg;

    // commanded climb limited to [-ascent, descent]
    always_comb begin
        lo_w  = -$signed({2'b00, asc_reg});
        hi_w  = $signed({2'b00, desc_reg});
        tc_w  = {tc_reg[DATA_W-1], tc_reg};
        tcc_w = tc_w;
        if (tc_w < lo_w) begin
            tcc_w = lo_w;
        end
        if (tc_w > hi_w) begin
            tcc_w = hi_w;
        end
    end

    // errors, integrator, accumulator, thrust saturation
    assign pe_s  = apc_pkg::apc_sat(PROD_W'(th_reg) - PROD_W'(mh_reg));
    assign ve_s  = apc_pkg::apc_sat(PROD_W'(tcc_reg) - PROD_W'(mc_reg));
    assign sum_s = apc_pkg::apc_sat(PROD_W'(sum_reg) + prod_sh);
    assign acc_s = apc_pkg::apc_sat(acc_reg);
    assign thr_s = apc_pkg::apc_sat(-prod_sh);

    // divider set-up: magnitudes and overflow check on the high dividend part
    always_comb begin
        num_neg = -num_reg;
        abs_num = num_reg[DATA_W] ? num_neg[DATA_W-1:0] : num_reg[DATA_W-1:0];
        r33_neg = -{r33_reg[COS_W-1], r33_reg};
        dmag    = r33_reg[COS_W-1] ? r33_neg[REM_W-1:0] : r33_reg[REM_W-1:0];
        dvd     = {abs_num, {FRAC_BITS{1'b0}}};
        dvd_hi  = dvd[DVD_W-1:QB];
        hi_ext  = {{REM_W{1'b0}}, dvd_hi};
        d_ext   = {{HI_W{1'b0}}, dmag};
        q_ovf   = hi_ext >= d_ext;
    end

    // restoring division step
    always_comb begin
        trial     = {rem_reg, dq_reg[QB-1]};
        trial_ge  = trial >= {1'b0, d_reg};
        trial_sub = trial - {1'b0, d_reg};
        mag_neg   = (QB + 1)'(0) - {1'b0, dq_reg};
    end

    // ------------------------------------------------------------------
    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            apc_pkg::ST_IDLE:  if (s_tvalid) state_next = apc_pkg::ST_CLAMP;
            apc_pkg::ST_CLAMP: state_next = apc_pkg::ST_ERR;
            apc_pkg::ST_ERR:   state_next = apc_pkg::ST_MPE;
            apc_pkg::ST_MPE:   state_next = apc_pkg::ST_MKP;
            apc_pkg::ST_MKP:   state_next = apc_pkg::ST_MKV;
            apc_pkg::ST_MKV:   state_next = apc_pkg::ST_MKI;
            apc_pkg::ST_MKI:   state_next = apc_pkg::ST_MACC;
            apc_pkg::ST_MACC:  state_next = apc_pkg::ST_ASAT;
            apc_pkg::ST_ASAT:  state_next = apc_pkg::ST_DINIT;
            apc_pkg::ST_DINIT: begin
                if (r33_reg == '0) begin
                    state_next = apc_pkg::ST_RES;
                end else if (q_ovf) begin
                    state_next = apc_pkg::ST_QSAT;
                end else begin
                    state_next = apc_pkg::ST_DIV;
                end
            end
            apc_pkg::ST_DIV: begin
                if (cnt_reg == CNT_W'(QB - 1)) state_next = apc_pkg::ST_QSAT;
            end
            apc_pkg::ST_QSAT:  state_next = apc_pkg::ST_MTH;
            apc_pkg::ST_MTH:   state_next = apc_pkg::ST_THR;
            apc_pkg::ST_THR:   state_next = apc_pkg::ST_RES;
            apc_pkg::ST_RES:   if (slot_free) state_next = apc_pkg::ST_IDLE;
            default:           state_next = apc_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: input ready and multiplier operands
    always_comb begin
        s_tready = 1'b0;
        mul_op.a = '0;
        mul_op.b = '0;
        unique case (state_reg)
            apc_pkg::ST_IDLE: s_tready = 1'b1;
            apc_pkg::ST_MPE: begin
                mul_op.a = OP_W'(pe_reg);
                mul_op.b = $signed({2'b00, dt_reg});
            end
            apc_pkg::ST_MKP: begin
                mul_op.a = $signed({2'b00, kp_reg});
                mul_op.b = OP_W'(pe_reg);
            end
            apc_pkg::ST_MKV: begin
                mul_op.a = $signed({2'b00, kv_reg});
                mul_op.b = OP_W'(ve_reg);
            end
            apc_pkg::ST_MKI: begin
                mul_op.a = $signed({2'b00, ki_reg});
                mul_op.b = OP_W'(sum_reg);
            end
            apc_pkg::ST_MTH: begin
                mul_op.a = OP_W'(c_reg);
                mul_op.b = $signed({2'b00, mass_reg});
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= apc_pkg::ST_IDLE;
            sum_reg   <= '0;
            kp_reg    <= '0;
            kv_reg    <= '0;
            ki_reg    <= '0;
            asc_reg   <= apc_pkg::RATE_RESET;
            desc_reg  <= apc_pkg::RATE_RESET;
            mass_reg  <= apc_pkg::MASS_RESET;
        end else begin
            state_reg <= state_next;
            if (state_reg == apc_pkg::ST_MKP) begin
                sum_reg <= sum_s.val;
            end
            // register writes
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    apc_pkg::REG_POS_GAIN:    kp_reg   <= cfg_data[GAIN_W-1:0];
                    apc_pkg::REG_VEL_GAIN:    kv_reg   <= cfg_data[GAIN_W-1:0];
                    apc_pkg::REG_INT_GAIN:    ki_reg   <= cfg_data[GAIN_W-1:0];
                    apc_pkg::REG_MAX_ASCENT:  asc_reg  <= cfg_data[GAIN_W-1:0];
                    apc_pkg::REG_MAX_DESCENT: desc_reg <= cfg_data[GAIN_W-1:0];
                    apc_pkg::REG_MASS:        mass_reg <= cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == apc_pkg::ST_RES && slot_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == apc_pkg::ST_RES && slot_free) begin
            m_tdata_reg <= res_reg;
            m_tuser_reg <= flag_reg;
        end
    end

    // ------------------------------------------------------------------
    // datapath registers, one step per state
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            apc_pkg::ST_IDLE: begin
                if (s_acc) begin
                    th_reg   <= s_tdata[31:0];
                    tc_reg   <= s_tdata[63:32];
                    mh_reg   <= s_tdata[95:64];
                    mc_reg   <= s_tdata[127:96];
                    ff_reg   <= s_tdata[159:128];
                    dt_reg   <= s_tdata[190:160];
                    r33_reg  <= s_tdata[208:191];
                    flag_reg <= 1'b0;
                end
            end
            apc_pkg::ST_CLAMP: begin
                tcc_reg  <= tcc_w[DATA_W-1:0];
                pe_reg   <= pe_s.val;
                flag_reg <= flag_reg | pe_s.ovf;
                acc_reg  <= PROD_W'(ff_reg);
            end
            apc_pkg::ST_ERR: begin
                ve_reg   <= ve_s.val;
                flag_reg <= flag_reg | ve_s.ovf;
            end
            apc_pkg::ST_MKP: begin
                flag_reg <= flag_reg | sum_s.ovf;
            end
            apc_pkg::ST_MKV, apc_pkg::ST_MKI, apc_pkg::ST_MACC: begin
                acc_reg <= acc_reg + prod_sh;
            end
            apc_pkg::ST_ASAT: begin
                num_reg  <= {acc_s.val[DATA_W-1], acc_s.val} - GRAVITY;
                flag_reg <= flag_reg | acc_s.ovf;
            end
            apc_pkg::ST_DINIT: begin
                d_reg   <= dmag;
                rem_reg <= hi_ext[REM_W-1:0];
                dq_reg  <= dvd[QB-1:0];
                cnt_reg <= '0;
                ovf_reg <= q_ovf;
                neg_reg <= num_reg[DATA_W] ^ r33_reg[COS_W-1];
                // zero R33: thrust goes to the low rail for a positive numerator, else to the high rail
                if (r33_reg == '0) begin
                    flag_reg <= 1'b1;
                    res_reg  <= (num_reg > 0) ? apc_pkg::Q_MIN : apc_pkg::Q_MAX;
                end
            end
            apc_pkg::ST_DIV: begin
                rem_reg <= trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
                dq_reg  <= {dq_reg[QB-2:0], trial_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            apc_pkg::ST_QSAT: begin
                // signed quotient, saturated to the word range
                if (ovf_reg) begin
                    c_reg    <= neg_reg ? apc_pkg::Q_MIN : apc_pkg::Q_MAX;
                    flag_reg <= 1'b1;
                end else if (neg_reg) begin
                    if (dq_reg > QB'(33'd2147483648)) begin
                        c_reg    <= apc_pkg::Q_MIN;
                        flag_reg <= 1'b1;
                    end else begin
                        c_reg <= mag_neg[DATA_W-1:0];
                    end
                end else begin
                    if (dq_reg > QB'(33'd2147483647)) begin
                        c_reg    <= apc_pkg::Q_MAX;
                        flag_reg <= 1'b1;
                    end else begin
                        c_reg <= dq_reg[DATA_W-1:0];
                    end
                end
            end
            apc_pkg::ST_THR: begin
                res_reg  <= thr_s.val;
                flag_reg <= flag_reg | thr_s.ovf;
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("input still ready after a word was taken");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == apc_pkg::ST_DIV) |-> (d_reg != '0))
        else $error("divider running with zero divisor");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == apc_pkg::ST_DIV) |-> (cnt_reg < CNT_W'(QB)))
        else $error("divider step count out of range");

    a_zero_tilt_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == apc_pkg::ST_RES && slot_free && r33_reg == '0) |=> m_tuser[0])
        else $error("zero R33 result without saturated flag");

    a_qovf_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == apc_pkg::ST_QSAT && ovf_reg) |=> flag_reg)
        else $error("quotient overflow without saturated flag");

endmodule

// ===== sim/altitude_pid_thrust_control_test.sv =====
// Self-checking testbench for the altitude PID thrust controller: directed corner
// words, then random words under several register settings, with random idling in some parts.
// Depends on apc_pkg and the controller RTL only.
module altitude_pid_thrust_control_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     S_TDATA_W    = apc_pkg::S_TDATA_W;
    localparam int     M_TDATA_W    = apc_pkg::M_TDATA_W;
    localparam int     CFG_IDX_W    = apc_pkg::CFG_IDX_W;
    localparam int     CFG_DAT_W    = apc_pkg::CFG_DAT_W;
    localparam int     FRAC_BITS    = 16;
    localparam int     ONE          = 1 << FRAC_BITS;
    localparam longint Q_ONE        = 64'sd1 << FRAC_BITS;
    localparam longint GRAVITY      = (981 * Q_ONE + 50) / 100;
    localparam longint Q_HI         = 64'sd2147483647;
    localparam longint Q_LO         = -64'sd2147483648;
    localparam int     HEIGHT_SPAN  = 100 * ONE;
    localparam int     LONG_HOLD_AT = 200;
    localparam int     LONG_HOLD    = 300;
    localparam int     STALL_LIMIT  = 5000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = apc_pkg::REG_MASS + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = apc_pkg::REG_MASS + 3'd2;

    // input word, laid out exactly as s_tdata (last field in the low bits)
    typedef struct packed {
        logic [6:0]         pad;
        logic signed [17:0] tilt_cosine;
        logic [30:0]        time_step;
        logic signed [31:0] feedforward_accel;
        logic signed [31:0] measured_climb;
        logic signed [31:0] measured_height;
        logic signed [31:0] target_climb;
        logic signed [31:0] target_height;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] thrust;
        logic               saturated;
    } thrust_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    sample_t pending_items[$];
    thrust_t thrust_expected[$];
    int      idle_pct = 0;
    int      mismatches = 0;
    int      results_checked = 0;

    // predictor copy of the registers and the integrator
    logic [30:0] kp, kv, ki, ascent_rate, descent_rate, mass;
    longint      height_sum = 0;

    altitude_pid_thrust_control #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic longint clip32(input longint v, output logic hit);
        hit = (v > Q_HI) || (v < Q_LO);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    // thrust for one word; advances the integrator
    function automatic thrust_t predict_thrust(input sample_t w);
        longint  climb_cmd, pos_err, vel_err, accel, num, quot, thr;
        logic    hit;
        thrust_t r;
        r.saturated = 1'b0;
        climb_cmd = longint'(w.target_climb);
        if (climb_cmd < -longint'(ascent_rate)) climb_cmd = -longint'(ascent_rate);
        if (climb_cmd > longint'(descent_rate)) climb_cmd = longint'(descent_rate);
        pos_err = clip32(longint'(w.target_height) - longint'(w.measured_height), hit);
        r.saturated |= hit;
        vel_err = clip32(climb_cmd - longint'(w.measured_climb), hit);
        r.saturated |= hit;
        height_sum = clip32(height_sum + ((pos_err * longint'(w.time_step)) >>> FRAC_BITS), hit);
        r.saturated |= hit;
        accel = ((longint'(kp) * pos_err) >>> FRAC_BITS)
              + ((longint'(kv) * vel_err) >>> FRAC_BITS)
              + ((longint'(ki) * height_sum) >>> FRAC_BITS)
              + longint'(w.feedforward_accel);
        accel = clip32(accel, hit);
        r.saturated |= hit;
        num = accel - GRAVITY;
        if (w.tilt_cosine == '0) begin
            // no tilt information: thrust pinned to a rail
            r.saturated = 1'b1;
            thr = (num > 0) ? Q_LO : Q_HI;
        end else begin
            quot = clip32((num * Q_ONE) / longint'(w.tilt_cosine), hit);
            r.saturated |= hit;
            thr = clip32(-((quot * longint'(mass)) >>> FRAC_BITS), hit);
            r.saturated |= hit;
        end
        r.thrust = 32'(thr);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: result %0d, %s: got %h, expected %h",
                 $realtime, results_checked, what, got, want);
    endtask

    task automatic queue_sample(input logic signed [31:0] th, input logic signed [31:0] tc,
                                input logic signed [31:0] mh, input logic signed [31:0] mc,
                                input logic signed [31:0] ff, input int dt,
                                input int cosine);
        sample_t s;
        s = '0;
        s.target_height     = th;
        s.target_climb      = tc;
        s.measured_height   = mh;
        s.measured_climb    = mc;
        s.feedforward_accel = ff;
        s.time_step         = 31'(dt);
        s.tilt_cosine       = 18'(cosine);
        pending_items.push_back(s);
    endtask

    // mostly plausible flight words, with full-range noise mixed in
    task automatic queue_random(input int count);
        sample_t s;
        int      base;
        repeat (count) begin
            s = '0;
            if ($urandom_range(0, 7) == 0) begin
                s.target_height     = $urandom;
                s.target_climb      = $urandom;
                s.measured_height   = $urandom;
                s.measured_climb    = $urandom;
                s.feedforward_accel = $urandom;
                s.time_step         = 31'($urandom);
                s.tilt_cosine       = 18'($urandom);
            end else begin
                base = int'($urandom_range(0, 2 * HEIGHT_SPAN)) - HEIGHT_SPAN;
                s.target_height     = base;
                s.measured_height   = base + int'($urandom_range(0, 10 * ONE)) - 5 * ONE;
                s.target_climb      = int'($urandom_range(0, 20 * ONE)) - 10 * ONE;
                s.measured_climb    = int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
                s.feedforward_accel = int'($urandom_range(0, 6 * ONE)) - 3 * ONE;
                s.time_step         = 31'($urandom_range(1, ONE / 10));
                s.tilt_cosine       = 18'($urandom_range(ONE / 2, ONE));
                if ($urandom_range(0, 15) == 0) s.tilt_cosine = -s.tilt_cosine;
                if ($urandom_range(0, 31) == 0) s.tilt_cosine = '0;
            end
            pending_items.push_back(s);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained;
        while (pending_items.size() != 0 || s_tvalid || thrust_expected.size() != 0)
            @(posedge aclk);
    endtask

    // input driver: one word from the pending queue at a time, random gaps
    always @(posedge aclk) begin : drive_words
        int gap_left;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() != 0 && $urandom_range(0, 399) >= idle_pct) begin
                s_tdata  <= pending_items.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
                if (pending_items.size() != 0) gap_left = $urandom_range(0, 17);
            end
        end
    end

    // result acceptor: random stall bursts, one long hold-off to fill the block
    always @(posedge aclk) begin : accept_results
        int hold_left;
        int taken;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left = 0;
            taken = 0;
        end else begin
            if (m_tvalid && m_tready) taken++;
            if (m_tvalid && m_tready && taken == LONG_HOLD_AT) begin
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 399) < idle_pct) begin
                hold_left = $urandom_range(0, 17);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // register mirror and expected thrust on every accepted word
    always @(posedge aclk) begin : predict_words
        if (!aresetn) begin
            kp = '0;
            kv = '0;
            ki = '0;
            ascent_rate  = apc_pkg::RATE_RESET;
            descent_rate = apc_pkg::RATE_RESET;
            mass         = apc_pkg::MASS_RESET;
            height_sum   = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    apc_pkg::REG_POS_GAIN:    kp = cfg_data[30:0];
                    apc_pkg::REG_VEL_GAIN:    kv = cfg_data[30:0];
                    apc_pkg::REG_INT_GAIN:    ki = cfg_data[30:0];
                    apc_pkg::REG_MAX_ASCENT:  ascent_rate  = cfg_data[30:0];
                    apc_pkg::REG_MAX_DESCENT: descent_rate = cfg_data[30:0];
                    apc_pkg::REG_MASS:        mass = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) thrust_expected.push_back(predict_thrust(s_tdata));
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge aclk) begin : check_results
        thrust_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (thrust_expected.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, '0);
            end else begin
                want = thrust_expected.pop_front();
                if (m_tdata !== want.thrust)
                    report_mismatch("thrust", m_tdata, want.thrust);
                if (m_tuser[0] !== want.saturated)
                    report_mismatch("saturated", 32'(m_tuser), 32'(want.saturated));
            end
            results_checked++;
        end
    end

    // stall watchdog: cycles with no handshake anywhere
    always @(posedge aclk) begin : watchdog
        int quiet;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", quiet);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        idle_pct <= 30;

        // reset register values: zero gains, so only errors and feed-forward matter
        queue_sample(0, 0, 0, 0, 0, 0, ONE);
        queue_sample(0, 0, 0, 0, 0, ONE, 0);
        queue_sample(0, 0, 0, 0, apc_pkg::Q_MAX, ONE, 0);
        queue_sample(0, 0, 0, 0, 32'(GRAVITY), ONE, 0);
        queue_sample(apc_pkg::Q_MAX, 0, apc_pkg::Q_MIN, 0, 0, 0, ONE);
        queue_sample(apc_pkg::Q_MIN, 0, apc_pkg::Q_MAX, 0, 0, 0, ONE);
        queue_sample(0, apc_pkg::Q_MAX, 0, apc_pkg::Q_MIN, 0, 0, ONE);
        queue_sample(0, apc_pkg::Q_MIN, 0, apc_pkg::Q_MAX, 0, 0, ONE);
        queue_sample(0, 32'(apc_pkg::RATE_RESET), 0, 0, 0, 0, ONE);
        queue_sample(0, -32'(apc_pkg::RATE_RESET), 0, 0, 0, 0, ONE);
        queue_sample(0, 0, 0, 0, apc_pkg::Q_MAX, 0, 1);
        queue_sample(0, 0, 0, 0, apc_pkg::Q_MIN, 0, 1);
        queue_sample(0, 0, 0, 0, ONE, 0, -ONE);
        queue_sample(0, 0, 0, 0, ONE, 0, 18'sh1ffff);
        queue_sample(0, 0, 0, 0, -ONE, 0, 18'sh20000);
        // integrator to both rails, then walked back to zero
        queue_sample(apc_pkg::Q_MAX, 0, 0, 0, 0, 31'h7fff_ffff, ONE);
        queue_sample(apc_pkg::Q_MIN, 0, 0, 0, 0, 31'h7fff_ffff, ONE);
        queue_sample(ONE, 0, 0, 0, 0, 31'h7fff_ffff, ONE);
        queue_sample(1, 0, 0, 0, 0, ONE, ONE);
        queue_random(100);
        wait_drained();

        // plausible tuning; the long hold-off falls in this part
        write_reg(apc_pkg::REG_POS_GAIN, 2 * ONE);
        write_reg(apc_pkg::REG_VEL_GAIN, 4 * ONE);
        write_reg(apc_pkg::REG_INT_GAIN, ONE / 2);
        write_reg(apc_pkg::REG_MAX_ASCENT, 3 * ONE);
        write_reg(apc_pkg::REG_MAX_DESCENT, ONE + ONE / 2);
        write_reg(apc_pkg::REG_MASS, ONE + ONE / 5);
        idle_pct <= 20;
        queue_random(250);
        wait_drained();

        // everything at its top value (bit 31 written to check it is dropped), rates zero
        write_reg(apc_pkg::REG_POS_GAIN, 32'hffff_ffff);
        write_reg(apc_pkg::REG_VEL_GAIN, 32'h7fff_ffff);
        write_reg(apc_pkg::REG_INT_GAIN, 32'hffff_ffff);
        write_reg(apc_pkg::REG_MAX_ASCENT, 0);
        write_reg(apc_pkg::REG_MAX_DESCENT, 0);
        write_reg(apc_pkg::REG_MASS, 32'h7fff_ffff);
        idle_pct <= 0;
        queue_sample(apc_pkg::Q_MAX, 0, 0, 0, 0, 0, ONE);
        queue_sample(apc_pkg::Q_MIN, 0, 0, 0, 0, 0, ONE);
        queue_sample(0, apc_pkg::Q_MAX, 0, 0, 0, 0, ONE);
        queue_sample(0, 0, 0, 0, 0, 0, -1);
        queue_random(120);
        wait_drained();

        // zero position and integral gains and mass, widest rate limits; spare indexes must be ignored
        write_reg(apc_pkg::REG_POS_GAIN, 0);
        write_reg(apc_pkg::REG_VEL_GAIN, ONE / 2);
        write_reg(apc_pkg::REG_INT_GAIN, 0);
        write_reg(apc_pkg::REG_MAX_ASCENT, 32'hffff_ffff);
        write_reg(apc_pkg::REG_MAX_DESCENT, 32'h7fff_ffff);
        write_reg(apc_pkg::REG_MASS, 0);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        idle_pct <= 40;
        queue_random(120);
        wait_drained();

        // random tuning, no idling to the end
        write_reg(apc_pkg::REG_POS_GAIN, $urandom_range(0, 4 * ONE));
        write_reg(apc_pkg::REG_VEL_GAIN, $urandom_range(0, 4 * ONE));
        write_reg(apc_pkg::REG_INT_GAIN, $urandom_range(0, ONE));
        write_reg(apc_pkg::REG_MAX_ASCENT, $urandom_range(0, 20 * ONE));
        write_reg(apc_pkg::REG_MAX_DESCENT, $urandom_range(0, 20 * ONE));
        write_reg(apc_pkg::REG_MASS, $urandom_range(ONE / 2, 5 * ONE));
        idle_pct <= 0;
        queue_random(250);
        wait_drained();

        // allow for any stray word beyond the last expected one
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && thrust_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== altitude_pid_thrust_control.f =====
rtl/apc_pkg.sv
rtl/apc_mul.sv
rtl/altitude_pid_thrust_control.sv
sim/altitude_pid_thrust_control_test.sv
